### design/assert_macros.svh
// Assertion macros shared by the slot table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(label, clk, rst, cond, msg)
`define CHK_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/lbst_pkg.sv
// Types and constants for the lifetime bundle slot table
package lbst_pkg;
   localparam int SLOT_COUNT = 16;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic [2:0] {
      OP_SAVE   = 3'd0,
      OP_DELETE = 3'd1,
      OP_READ   = 3'd2,
      OP_PRUNE  = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_NO_ROOM   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CAUSE_EXPIRED = 2'd0,
      CAUSE_EVICTED = 2'd1,
      CAUSE_DELETE  = 2'd2
   } cause_type;

   typedef enum logic [0:0] {
      EV_FINAL  = 1'b0,
      EV_REMOVE = 1'b1
   } event_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_PRUNE,
      S_EVICT,
      S_CLEAR,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] rtime;
      logic [31:0] life;
   } slot_type;

   typedef struct packed {
      logic          remove;
      logic          append;
      logic [CW-1:0] idx;
   } chain_ctl_type;
endpackage

### design/lbst_cell.sv
// One slot cell: holds a bundle and takes its neighbor's on removal
module lbst_cell
   import lbst_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  logic     load_en,
   input  slot_type neighbor,
   input  slot_type fresh,
   output slot_type slot
);
   slot_type slot_ff;

   // load a new bundle, or close the gap left by a removal
   always_ff @(posedge clock) begin
      if (load_en) begin
         slot_ff <= fresh;
      end else if (shift_en) begin
         slot_ff <= neighbor;
      end
   end

   assign slot = slot_ff;
endmodule

### design/lbst_chain.sv
// Row of slot cells with shift-on-remove and append control
module lbst_chain
   import lbst_pkg::*;
(
   input  logic          clock,
   input  chain_ctl_type ctl,
   input  slot_type      fresh,
   output slot_type      rd_slot
);
   slot_type slots [SLOT_COUNT];
   slot_type nbrs  [SLOT_COUNT];

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      logic shift_en;
      logic load_en;
      assign shift_en = ctl.remove && (CW'(g) >= ctl.idx);
      assign load_en  = ctl.append && (CW'(g) == ctl.idx);
      if (g == SLOT_COUNT - 1) begin : g_tail
         assign nbrs[g] = '0;
      end else begin : g_mid
         assign nbrs[g] = slots[g + 1];
      end
      lbst_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .load_en  (load_en),
         .neighbor (nbrs[g]),
         .fresh    (fresh),
         .slot     (slots[g])
      );
   end

   // read the slot under the scan index
   assign rd_slot = slots[ctl.idx[IW-1:0]];
endmodule

### design/lifetime_bundle_slot_table.sv
// One slot is examined per cycle while a stalled result does not hold the walk.
// A save walks the row for a duplicate, then for expired slots, then for an eviction.
// Throughput: one request at a time; req_stall is high until the final beat is issued.
// Each result beat is issued through an output register; a stalled result halts the walk.
// Reset (synchronous, active high) empties the table; slot contents are not cleared.
module lifetime_bundle_slot_table
   import lbst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_bundle_id,
   input  logic [31:0] req_receive_time,
   input  logic [31:0] req_life_seconds,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_kind,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_affected_id,
   output logic [1:0]  rsp_removal_cause,
   output logic [31:0] rsp_remaining_life,
   output logic [6:0]  rsp_entries_held,
   output logic        rsp_last_result
);
`include "assert_macros.svh"

   state_type     state_ff, state_in;
   logic [2:0]    op_ff;
   logic [31:0]   id_ff, rt_ff, life_ff, now_ff, new_rem_ff;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in;

   logic          rsp_valid_ff;
   logic          kind_ff;
   logic [1:0]    status_ff, cause_ff;
   logic [31:0]   aid_ff, rem_ff;
   logic [CW-1:0] held_ff;
   logic          last_ff;

   logic          emit, e_kind, e_last;
   logic [1:0]    e_status, e_cause;
   logic [31:0]   e_id, e_rem;
   logic [CW-1:0] e_held;
   chain_ctl_type ctl;
   slot_type      cur, fresh;

   logic        accept, step, at_end, full, hit_id, expired, evict_ok;
   logic [31:0] elapsed, cur_rem;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign step   = !rsp_valid_ff || !rsp_stall;
   assign at_end = (idx_ff == count_ff);
   assign full   = (count_ff == CW'(SLOT_COUNT));

   // per-slot tests on the slot under the scan index
   assign elapsed  = now_ff - cur.rtime;
   assign cur_rem  = cur.life - elapsed;
   assign hit_id   = (cur.id == id_ff);
   assign expired  = (cur.life < elapsed);
   assign evict_ok = (new_rem_ff >= cur_rem);

   assign fresh = '{id: id_ff, rtime: rt_ff, life: life_ff};

   lbst_chain u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .fresh   (fresh),
      .rd_slot (cur)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_SAVE, OP_DELETE, OP_READ: state_in = S_FIND;
                  OP_PRUNE: state_in = S_PRUNE;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_FINAL;
               endcase
            end
         end
         S_FIND: begin
            if (step) begin
               if (at_end) begin
                  state_in = (op_ff == OP_SAVE) ? S_PRUNE : S_IDLE;
               end else if (hit_id) begin
                  state_in = (op_ff == OP_DELETE) ? S_FINAL : S_IDLE;
               end
            end
         end
         S_PRUNE: begin
            if (step && at_end) begin
               state_in = (op_ff == OP_SAVE) ? S_EVICT : S_IDLE;
            end
         end
         S_EVICT: begin
            if (step && (!full || at_end)) begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (step && (count_ff == '0)) begin
               state_in = S_IDLE;
            end
         end
         S_FINAL: begin
            if (step) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // walk actions and result beats
   always_comb begin
      emit     = 1'b0;
      e_kind   = EV_FINAL;
      e_status = ST_OK;
      e_id     = '0;
      e_cause  = CAUSE_EXPIRED;
      e_rem    = '0;
      e_held   = count_ff;
      e_last   = 1'b1;
      ctl      = '{remove: 1'b0, append: 1'b0, idx: idx_ff};
      idx_in   = idx_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
            end
         end
         S_FIND: begin
            if (step) begin
               if (at_end) begin
                  idx_in = '0;
                  if (op_ff != OP_SAVE) begin
                     emit     = 1'b1;
                     e_status = ST_NOT_FOUND;
                     e_id     = id_ff;
                  end
               end else if (hit_id) begin
                  e_id = id_ff;
                  emit = 1'b1;
                  case (op_ff)
                     OP_SAVE: e_status = ST_DUPLICATE;
                     OP_DELETE: begin
                        ctl.remove = 1'b1;
                        count_in   = count_ff - 1'b1;
                        e_held     = count_ff - 1'b1;
                        e_kind     = EV_REMOVE;
                        e_cause    = CAUSE_DELETE;
                        e_last     = 1'b0;
                     end
                     default: e_rem = expired ? '0 : cur_rem;
                  endcase
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_PRUNE: begin
            if (step) begin
               if (at_end) begin
                  idx_in = '0;
                  if (op_ff == OP_PRUNE) begin
                     emit = 1'b1;
                  end
               end else if (expired) begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
                  emit       = 1'b1;
                  e_kind     = EV_REMOVE;
                  e_id       = cur.id;
                  e_held     = count_ff - 1'b1;
                  e_last     = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_EVICT: begin
            if (step) begin
               if (!full) begin
                  ctl.append = 1'b1;
                  ctl.idx    = count_ff;
                  count_in   = count_ff + 1'b1;
                  emit       = 1'b1;
                  e_id       = id_ff;
                  e_held     = count_ff + 1'b1;
               end else if (at_end) begin
                  emit     = 1'b1;
                  e_status = ST_NO_ROOM;
                  e_id     = id_ff;
               end else if (evict_ok) begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
                  idx_in     = '0;
                  emit       = 1'b1;
                  e_kind     = EV_REMOVE;
                  e_cause    = CAUSE_EVICTED;
                  e_id       = cur.id;
                  e_held     = count_ff - 1'b1;
                  e_last     = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_CLEAR: begin
            if (step) begin
               emit = 1'b1;
               if (count_ff != '0) begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
                  e_kind     = EV_REMOVE;
                  e_cause    = CAUSE_EVICTED;
                  e_id       = cur.id;
                  e_held     = count_ff - 1'b1;
                  e_last     = 1'b0;
               end
            end
         end
         S_FINAL: begin
            if (step) begin
               emit = 1'b1;
               e_id = (op_ff == OP_DELETE) ? id_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request and the scan index
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         op_ff      <= req_opcode;
         id_ff      <= req_bundle_id;
         rt_ff      <= req_receive_time;
         life_ff    <= req_life_seconds;
         now_ff     <= req_now_seconds;
         new_rem_ff <= req_life_seconds - (req_now_seconds - req_receive_time);
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= e_kind;
         status_ff <= e_status;
         aid_ff    <= e_id;
         cause_ff  <= e_cause;
         rem_ff    <= e_rem;
         held_ff   <= e_held;
         last_ff   <= e_last;
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_status         = status_ff;
   assign rsp_affected_id    = aid_ff;
   assign rsp_removal_cause  = cause_ff;
   assign rsp_remaining_life = rem_ff;
   assign rsp_entries_held   = 7'(held_ff);
   assign rsp_last_result    = last_ff;

   `CHK_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(SLOT_COUNT), "slot count overflow")
   `CHK_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE, "accept did not start walk")
   `CHK_NEXT(a_idle_count, clock, reset, state_ff == S_IDLE, $stable(count_ff), "count moved idle")
   `CHK_ALWAYS(a_last_final, clock, reset, !(rsp_valid_ff && last_ff) || (kind_ff == EV_FINAL), "last beat not final")
endmodule

### sim/testbench.sv
// Testbench for the lifetime bundle slot table: directed and random operations checked per beat
`timescale 1ns / 1ps
module testbench;
   import lbst_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [31:0] id;
      logic [1:0]  cause;
      logic [31:0] rem;
      logic [6:0]  held;
      logic        last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [31:0] req_bundle_id = '0;
   logic [31:0] req_receive_time = '0;
   logic [31:0] req_life_seconds = '0;
   logic [31:0] req_now_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_event_kind;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_affected_id;
   logic [1:0]  rsp_removal_cause;
   logic [31:0] rsp_remaining_life;
   logic [6:0]  rsp_entries_held;
   logic        rsp_last_result;

   // predictor copy of the table
   logic [31:0] tbl_id [SLOT_COUNT];
   logic [31:0] tbl_rt [SLOT_COUNT];
   logic [31:0] tbl_life [SLOT_COUNT];
   int          tbl_count = 0;

   beat_type    expected_beats [$];
   int          errors = 0;
   longint      cycles = 0;
   bit          quiet = 1'b0;
   logic [31:0] clock_now = 32'd1000;

   lifetime_bundle_slot_table DUT (.*);

   always #2 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   function automatic void push_beat(logic kind, logic [1:0] st, logic [31:0] id,
                                     logic [1:0] cause, logic [31:0] rem, logic last);
      beat_type b;
      b.kind = kind; b.status = st; b.id = id; b.cause = cause; b.rem = rem;
      b.held = 7'(tbl_count); b.last = last;
      expected_beats.push_back(b);
   endfunction

   function automatic int find_slot(logic [31:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void remove_slot(int idx, logic [1:0] cause);
      logic [31:0] id;
      id = tbl_id[idx];
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_id[i] = tbl_id[i+1]; tbl_rt[i] = tbl_rt[i+1]; tbl_life[i] = tbl_life[i+1];
      end
      tbl_count--;
      push_beat(EV_REMOVE, ST_OK, id, cause, '0, 1'b0);
   endfunction

   function automatic void prune_expired(logic [31:0] now);
      int i;
      i = 0;
      while (i < tbl_count) begin
         if (tbl_life[i] < 32'(now - tbl_rt[i])) remove_slot(i, CAUSE_EXPIRED);
         else i++;
      end
   endfunction

   // compute expected beats for one request
   function automatic void predict_table(logic [2:0] op, logic [31:0] id, logic [31:0] rt,
                                         logic [31:0] life, logic [31:0] now);
      int k, hit;
      logic [31:0] new_rem, elapsed;
      case (op)
         OP_SAVE: begin
            if (find_slot(id) >= 0) begin
               push_beat(EV_FINAL, ST_DUPLICATE, id, '0, '0, 1'b1);
               return;
            end
            prune_expired(now);
            new_rem = life - (now - rt);
            while (tbl_count >= SLOT_COUNT) begin
               hit = -1;
               for (int i = 0; i < tbl_count; i++)
                  if (hit < 0 && new_rem >= 32'(tbl_life[i] - (now - tbl_rt[i]))) hit = i;
               if (hit < 0) break;
               remove_slot(hit, CAUSE_EVICTED);
            end
            if (tbl_count >= SLOT_COUNT) begin
               push_beat(EV_FINAL, ST_NO_ROOM, id, '0, '0, 1'b1);
               return;
            end
            tbl_id[tbl_count] = id; tbl_rt[tbl_count] = rt; tbl_life[tbl_count] = life;
            tbl_count++;
            push_beat(EV_FINAL, ST_OK, id, '0, '0, 1'b1);
         end
         OP_DELETE: begin
            k = find_slot(id);
            if (k < 0) push_beat(EV_FINAL, ST_NOT_FOUND, id, '0, '0, 1'b1);
            else begin
               remove_slot(k, CAUSE_DELETE);
               push_beat(EV_FINAL, ST_OK, id, '0, '0, 1'b1);
            end
         end
         OP_READ: begin
            k = find_slot(id);
            if (k < 0) push_beat(EV_FINAL, ST_NOT_FOUND, id, '0, '0, 1'b1);
            else begin
               elapsed = now - tbl_rt[k];
               push_beat(EV_FINAL, ST_OK, id, '0,
                         (tbl_life[k] < elapsed) ? 32'd0 : tbl_life[k] - elapsed, 1'b1);
            end
         end
         OP_PRUNE: begin
            prune_expired(now);
            push_beat(EV_FINAL, ST_OK, '0, '0, '0, 1'b1);
         end
         OP_CLEAR: begin
            while (tbl_count > 0) remove_slot(0, CAUSE_EVICTED);
            push_beat(EV_FINAL, ST_OK, '0, '0, '0, 1'b1);
         end
         default: push_beat(EV_FINAL, ST_OK, '0, '0, '0, 1'b1);
      endcase
   endfunction

   // drive one request beat and wait for acceptance
   task automatic send_request(logic [2:0] op, logic [31:0] id, logic [31:0] rt,
                               logic [31:0] life, logic [31:0] now);
      int gap;
      // step past the edge where valid was dropped
      gap = 1;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clock);
      req_valid <= 1'b1; req_opcode <= op; req_bundle_id <= id;
      req_receive_time <= rt; req_life_seconds <= life; req_now_seconds <= now;
      predict_table(op, id, rt, life, now);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // stall the result side in random bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted result beat
   always @(posedge clock) begin
      beat_type got, exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_event_kind, rsp_status, rsp_affected_id, rsp_removal_cause,
                rsp_remaining_life, rsp_entries_held, rsp_last_result};
         if (expected_beats.size() == 0) report("result beat with nothing expected");
         else begin
            exp_b = expected_beats.pop_front();
            if (got.kind != exp_b.kind) report("event_kind");
            if (got.status != exp_b.status) report("status");
            if (got.id != exp_b.id) report("affected_id");
            if (got.cause != exp_b.cause) report("removal_cause");
            if (got.rem != exp_b.rem) report("remaining_life");
            if (got.held != exp_b.held) report("entries_held");
            if (got.last != exp_b.last) report("last_result");
         end
      end
   end

   task automatic drain_results();
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (2 * SLOT_COUNT + 10) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_id();
      return (32'($urandom_range(0, 3)) == 0) ? $urandom : 32'($urandom_range(0, 23));
   endfunction

   task automatic test_directed();
      send_request(OP_READ, 32'd5, 0, 0, clock_now);
      send_request(OP_DELETE, 32'hFFFF_FFFF, 0, 0, clock_now);
      send_request(OP_SAVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_request(OP_SAVE, 32'hFFFF_FFFF, 0, 0, 0);
      send_request(OP_READ, 32'hFFFF_FFFF, 0, 0, 32'd7);
      send_request(OP_SAVE, 32'd0, 32'd100, 32'd0, 32'd100);
      send_request(OP_READ, 32'd0, 0, 0, 32'd101);
      send_request(OP_PRUNE, 0, 0, 0, 32'd101);
      send_request(OP_DELETE, 32'hFFFF_FFFF, 0, 0, 0);
      for (int i = 0; i < SLOT_COUNT; i++)
         send_request(OP_SAVE, 32'(i + 1), 32'd50, 32'(1000 + i), 32'd60);
      send_request(OP_SAVE, 32'd99, 32'd60, 32'd100, 32'd60);
      send_request(OP_SAVE, 32'd98, 32'd60, 32'd5000, 32'd60);
      send_request(3'd5, 32'd1, 0, 0, 0);
      send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_CLEAR, 0, 0, 0, 0);
      drain_results();
   endtask

   // mostly saves with short lifetimes so pruning and eviction both occur
   task automatic test_random(int count);
      logic [2:0] op;
      int r;
      for (int n = 0; n < count; n++) begin
         if (n > count - 40) quiet = 1'b1;
         clock_now = clock_now + 32'($urandom_range(0, 30));
         r = $urandom_range(0, 99);
         op = (r < 55) ? OP_SAVE : (r < 70) ? OP_READ : (r < 82) ? OP_DELETE :
              (r < 92) ? OP_PRUNE : (r < 96) ? OP_CLEAR : 3'($urandom_range(5, 7));
         if (r % 17 == 0)
            send_request(op, $urandom, $urandom, $urandom, $urandom);
         else
            send_request(op, pick_id(), clock_now - 32'($urandom_range(0, 40)),
                         32'($urandom_range(0, 200)), clock_now);
      end
      drain_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(320);
      if (errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end
endmodule

### lifetime_bundle_slot_table.f
+incdir+design
design/lbst_pkg.sv
design/lbst_cell.sv
design/lbst_chain.sv
design/lifetime_bundle_slot_table.sv
sim/testbench.sv
